// ===== design/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/ttbl_pkg.sv =====
package ttbl_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int TEMP_W        = 10;
  localparam int TABLE_POINTS  = 103;
  localparam int POINT_SPACING = 10;
  localparam int FIRST_COUNT   = 1;
  localparam int LAST_POINT    = TABLE_POINTS - 1;
  localparam int TOP_COUNT     = FIRST_COUNT + POINT_SPACING * LAST_POINT;

  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam int OFF_W = (POINT_SPACING > 1) ? $clog2(POINT_SPACING) : 1;

  // index = d / spacing through a floor reciprocal, one correction step after
  localparam int RECIP_SHIFT = 16;
  localparam int SP_RECIP    = (1 << RECIP_SHIFT) / POINT_SPACING;
  localparam int RECIP_W     = $clog2(SP_RECIP + 1);

  // table entries in hundredths of a degree
  localparam int ROM_W = 17;
  localparam int NUM_W = ROM_W + $clog2(POINT_SPACING + 1);

  // final scale: num / (spacing * 100), again by floor reciprocal
  localparam int DIV         = POINT_SPACING * 100;
  localparam int DIV_SHIFT   = NUM_W;
  localparam int DIV_RECIP   = (1 << DIV_SHIFT) / DIV;
  localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_POINT);

  localparam logic signed [ROM_W-1:0] ROM [TABLE_POINTS] = '{
    -17'sd8699, -17'sd5905, -17'sd4991, -17'sd4396, -17'sd3945,
    -17'sd3576, -17'sd3261, -17'sd2984, -17'sd2737, -17'sd2511,
    -17'sd2303, -17'sd2110, -17'sd1929, -17'sd1758, -17'sd1595,
    -17'sd1441, -17'sd1292, -17'sd1150, -17'sd1012, -17'sd879,
    -17'sd750,  -17'sd625,  -17'sd503,  -17'sd383,  -17'sd266,
    -17'sd152,  -17'sd40,   17'sd71,    17'sd180,   17'sd287,
    17'sd393,   17'sd497,   17'sd601,   17'sd703,   17'sd805,
    17'sd905,   17'sd1006,  17'sd1105,  17'sd1204,  17'sd1303,
    17'sd1402,  17'sd1500,  17'sd1598,  17'sd1696,  17'sd1795,
    17'sd1893,  17'sd1992,  17'sd2090,  17'sd2190,  17'sd2289,
    17'sd2389,  17'sd2490,  17'sd2591,  17'sd2693,  17'sd2796,
    17'sd2900,  17'sd3005,  17'sd3111,  17'sd3219,  17'sd3327,
    17'sd3437,  17'sd3549,  17'sd3663,  17'sd3778,  17'sd3895,
    17'sd4014,  17'sd4136,  17'sd4260,  17'sd4387,  17'sd4517,
    17'sd4650,  17'sd4786,  17'sd4926,  17'sd5070,  17'sd5218,
    17'sd5371,  17'sd5529,  17'sd5692,  17'sd5862,  17'sd6038,
    17'sd6222,  17'sd6414,  17'sd6615,  17'sd6826,  17'sd7049,
    17'sd7284,  17'sd7534,  17'sd7801,  17'sd8087,  17'sd8395,
    17'sd8730,  17'sd9096,  17'sd9500,  17'sd9952,  17'sd10462,
    17'sd11048, 17'sd11736, 17'sd12567, 17'sd13609, 17'sd14994,
    17'sd17020, 17'sd20611, 17'sd33042
  };

  typedef struct packed {
    logic                ok;
    logic [SAMPLE_W-1:0] idx;
    logic [OFF_W-1:0]    off;
  } idx_word_t;

  typedef struct packed {
    logic                    ok;
    logic signed [NUM_W-1:0] num;
  } mac_word_t;

  // index saturates at the last stored point
  function automatic logic signed [ROM_W-1:0] rom_read(input logic [SAMPLE_W:0] i);
    logic [IDX_W-1:0] k;
    if (i > (SAMPLE_W+1)'(LAST_POINT)) begin
      k = LAST_IDX;
    end else begin
      k = i[IDX_W-1:0];
    end
    return ROM[k];
  endfunction

endpackage

// ===== design/thermistor_table_interpolator_core.sv =====
// thermistor table interpolator
// in channel: in_valid / in_ready carry one 10-bit adc word (in_adc_sample).
// out channel: out_valid / out_ready carry out_temperature (signed whole
// degrees C, truncated toward zero) and out_in_range.
// a sample of 0 or above the last table point gives out_in_range = 0 and a
// temperature of 0; a sample on the last point returns the last entry.
// structure: nine register stages carry each word from the input to the
// output register.
// throughput: one word per cycle while out_ready is high; the stages are
// range check, index divide, index correction, table read, multiply-add,
// magnitude, reciprocal multiply, quotient correction and output register.
// stall: when the output register holds a word that is not taken, the whole
// pipe holds and in_ready drops; nothing is dropped or repeated.
// reset: rst_n (synchronous, active low) clears all stage valid bits; the
// block is ready to take words as soon as reset is released.
`include "assert_macros.svh"

module thermistor_table_interpolator_core import ttbl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SAMPLE_W-1:0]      in_adc_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] out_temperature,
  output logic                     out_in_range
);

  logic      en;
  logic      idx_vld, mac_vld;
  idx_word_t idx_word;
  mac_word_t mac_word;
  logic [TEMP_W-1:0] temp;

  // pipe advances whenever the output register is empty or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  ttbl_index u_index (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_i    (in_valid),
    .sample_i (in_adc_sample),
    .vld_o    (idx_vld),
    .word_o   (idx_word)
  );

  ttbl_lookup u_lookup (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (idx_vld),
    .word_i (idx_word),
    .vld_o  (mac_vld),
    .word_o (mac_word)
  );

  ttbl_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_i      (mac_vld),
    .word_i     (mac_word),
    .vld_o      (out_valid),
    .temp_o     (temp),
    .in_range_o (out_in_range)
  );

  assign out_temperature = signed'(temp);

  `ASSERT_CLK(a_stall_blocks_input, clk, rst_n, (out_valid && !out_ready) |-> !in_ready)
  `ASSERT_CLK(a_out_held, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_temperature))
  `ASSERT_NEVER(a_out_of_range_zero, clk, rst_n, out_valid && !out_in_range && out_temperature != '0)
  `ASSERT_CLK(a_hold_on_stall, clk, rst_n, (out_valid && !out_ready) |=> (mac_vld == $past(mac_vld)))

endmodule

// ===== design/ttbl_index.sv =====
module ttbl_index import ttbl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                vld_o,
  output idx_word_t           word_o
);

  localparam int PROD_W = SAMPLE_W + RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0]  SP_RECIP_V = RECIP_W'(SP_RECIP);
  localparam logic [SAMPLE_W-1:0] SP_V       = SAMPLE_W'(POINT_SPACING);
  localparam logic [SAMPLE_W-1:0] FIRST_V    = SAMPLE_W'(FIRST_COUNT);
  localparam logic [SAMPLE_W:0]   TOP_V      = (SAMPLE_W+1)'(TOP_COUNT);

  logic                v1_r, v2_r, v3_r;
  logic                ok1_r, ok2_r;
  logic [SAMPLE_W-1:0] d1_r, d2_r, q2_r;
  idx_word_t           w3_r;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] rem;
  idx_word_t           w3_nxt;

  assign prod = PROD_W'(d1_r) * PROD_W'(SP_RECIP_V);
  assign rem  = d2_r - (q2_r * SP_V);

  // estimate is low by at most one
  always_comb begin
    w3_nxt.ok = ok2_r;
    if (rem >= SP_V) begin
      w3_nxt.idx = q2_r + 1'b1;
      w3_nxt.off = OFF_W'(rem - SP_V);
    end else begin
      w3_nxt.idx = q2_r;
      w3_nxt.off = OFF_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1_r <= (sample_i >= FIRST_V) && ({1'b0, sample_i} <= TOP_V);
      d1_r  <= sample_i - FIRST_V;
      ok2_r <= ok1_r;
      d2_r  <= d1_r;
      q2_r  <= prod[RECIP_SHIFT +: SAMPLE_W];
      w3_r  <= w3_nxt;
    end
  end

  assign vld_o  = v3_r;
  assign word_o = w3_r;

endmodule

// ===== design/ttbl_lookup.sv =====
module ttbl_lookup import ttbl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      vld_i,
  input  idx_word_t word_i,
  output logic      vld_o,
  output mac_word_t word_o
);

  localparam int MAC_W = NUM_W + 1;
  localparam logic [SAMPLE_W:0]       TP_V = (SAMPLE_W+1)'(TABLE_POINTS);
  localparam logic signed [MAC_W-1:0] SP_S = MAC_W'(POINT_SPACING);

  logic                    v4_r, v5_r;
  logic                    ok4_r;
  logic signed [ROM_W-1:0] lo4_r;
  logic signed [ROM_W:0]   diff4_r;
  logic [OFF_W-1:0]        off4_r;
  mac_word_t               w5_r;

  logic [SAMPLE_W:0]       ip1;
  logic signed [ROM_W-1:0] lo, hi;
  logic signed [MAC_W-1:0] term_a, term_b, sum;

  assign ip1 = {1'b0, word_i.idx} + 1'b1;
  assign lo  = rom_read({1'b0, word_i.idx});
  // last point has no upper neighbor
  assign hi  = (ip1 < TP_V) ? rom_read(ip1) : lo;

  assign term_a = MAC_W'(lo4_r) * SP_S;
  assign term_b = MAC_W'(diff4_r) * MAC_W'(signed'({1'b0, off4_r}));
  assign sum    = term_a + term_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= vld_i;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4_r    <= word_i.ok;
      lo4_r    <= lo;
      diff4_r  <= {hi[ROM_W-1], hi} - {lo[ROM_W-1], lo};
      off4_r   <= word_i.off;
      w5_r.ok  <= ok4_r;
      w5_r.num <= sum[NUM_W-1:0];
    end
  end

  assign vld_o  = v5_r;
  assign word_o = w5_r;

endmodule

// ===== design/ttbl_scale.sv =====
module ttbl_scale import ttbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  mac_word_t         word_i,
  output logic              vld_o,
  output logic [TEMP_W-1:0] temp_o,
  output logic              in_range_o
);

  localparam int PROD_W = DIV_SHIFT + NUM_W;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP_V = DIV_RECIP_W'(DIV_RECIP);
  localparam logic [NUM_W-1:0]       DIV_V       = NUM_W'(DIV);

  logic              v6_r, v7_r, v8_r, v9_r;
  logic              ok6_r, ok7_r, ok8_r;
  logic              neg6_r, neg7_r, neg8_r;
  logic [NUM_W-1:0]  a6_r, a7_r, q7_r, q8_r;
  logic [TEMP_W-1:0] temp9_r;
  logic              rng9_r;

  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  q8_nxt;
  logic [NUM_W-1:0]  sgn_q;

  assign prod = PROD_W'(a6_r) * PROD_W'(DIV_RECIP_V);
  assign rem  = a7_r - (q7_r * DIV_V);

  // floor reciprocal may leave the quotient one short
  assign q8_nxt = (rem >= DIV_V) ? q7_r + 1'b1 : q7_r;
  assign sgn_q  = neg8_r ? -q8_r : q8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v6_r <= vld_i;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok6_r   <= word_i.ok;
      neg6_r  <= word_i.num[NUM_W-1];
      a6_r    <= word_i.num[NUM_W-1] ? -word_i.num : word_i.num;
      ok7_r   <= ok6_r;
      neg7_r  <= neg6_r;
      a7_r    <= a6_r;
      q7_r    <= prod[DIV_SHIFT +: NUM_W];
      ok8_r   <= ok7_r;
      neg8_r  <= neg7_r;
      q8_r    <= q8_nxt;
      rng9_r  <= ok8_r;
      temp9_r <= ok8_r ? sgn_q[TEMP_W-1:0] : '0;
    end
  end

  assign vld_o      = v9_r;
  assign temp_o     = temp9_r;
  assign in_range_o = rng9_r;

endmodule

// ===== tb/sv/thermistor_table_interpolator_core_tb.sv =====
`timescale 1ns / 100ps

module thermistor_table_interpolator_core_tb;
  import ttbl_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     in_range;
  } reading_t;

  // calibration points in hundredths of a degree, one per spacing step
  localparam int CURVE_CENTI [TABLE_POINTS] = '{
    -8699, -5905, -4991, -4396, -3945, -3576, -3261, -2984, -2737, -2511,
    -2303, -2110, -1929, -1758, -1595, -1441, -1292, -1150, -1012, -879,
    -750, -625, -503, -383, -266, -152, -40, 71, 180, 287,
    393, 497, 601, 703, 805, 905, 1006, 1105, 1204, 1303,
    1402, 1500, 1598, 1696, 1795, 1893, 1992, 2090, 2190, 2289,
    2389, 2490, 2591, 2693, 2796, 2900, 3005, 3111, 3219, 3327,
    3437, 3549, 3663, 3778, 3895, 4014, 4136, 4260, 4387, 4517,
    4650, 4786, 4926, 5070, 5218, 5371, 5529, 5692, 5862, 6038,
    6222, 6414, 6615, 6826, 7049, 7284, 7534, 7801, 8087, 8395,
    8730, 9096, 9500, 9952, 10462, 11048, 11736, 12567, 13609, 14994,
    17020, 20611, 33042
  };

  localparam int RANDOM_WORDS = 1200;
  localparam int HOLD_OFF_CYCLES = 150;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SAMPLE_W-1:0]      in_adc_sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature;
  logic                     out_in_range;

  logic [SAMPLE_W-1:0] sample_backlog[$];
  reading_t            expected_readings[$];
  int                  total_words;
  int                  accepted_cnt = 0;
  int                  err_count = 0;
  int                  burst_left = 1;
  int                  gap_left = 0;
  int                  rx_cycle = 0;
  int                  rx_mode = 0;
  logic                hold_off = 1'b0;

  thermistor_table_interpolator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_temperature (out_temperature),
    .out_in_range    (out_in_range)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // linear interpolation between neighboring points, truncated toward zero
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] sample);
    reading_t r;
    int       d;
    int       idx;
    int       off;
    int       lo;
    int       hi;
    int       num;
    r.temp = '0;
    r.in_range = 1'b0;
    if (int'(sample) >= FIRST_COUNT && int'(sample) <= TOP_COUNT) begin
      d = int'(sample) - FIRST_COUNT;
      idx = d / POINT_SPACING;
      off = d % POINT_SPACING;
      if (idx > TABLE_POINTS - 1) idx = TABLE_POINTS - 1;
      lo = CURVE_CENTI[idx];
      hi = (idx + 1 < TABLE_POINTS) ? CURVE_CENTI[idx + 1] : lo;
      num = lo * POINT_SPACING + (hi - lo) * off;
      r.temp = TEMP_W'(num / (POINT_SPACING * 100));
      r.in_range = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 50) begin
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // driver: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(in_adc_sample));
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          in_adc_sample <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: out_ready follows one of four stall patterns, drawn anew at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // long receiver hold-off so the pipe fills and in_ready drops
  initial begin
    while (accepted_cnt < 400) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected word, temperature", int'(out_temperature), 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature !== want.temp) begin
          report_mismatch("temperature", int'(out_temperature), int'(want.temp));
        end
        if (out_in_range !== want.in_range) begin
          report_mismatch("in_range", int'(out_in_range), int'(want.in_range));
        end
      end
    end
  end

  initial begin
    int pick;
    int k;
    // edges of the span, first and last points, the zero crossing, bit patterns
    sample_backlog = '{10'd0, 10'd1, 10'd2, 10'd10, 10'd11, 10'd12, 10'd6,
                       10'd261, 10'd262, 10'd265, 10'd270, 10'd271,
                       10'd341, 10'd682, 10'd511, 10'd512,
                       10'd1011, 10'd1012, 10'd1020, 10'd1021, 10'd1022, 10'd1023};
    for (k = 0; k < RANDOM_WORDS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        sample_backlog.push_back(SAMPLE_W'($urandom_range(0, 1023)));
      end else if (pick < 80) begin
        // exactly on a table point
        sample_backlog.push_back(SAMPLE_W'(FIRST_COUNT +
                                           POINT_SPACING * $urandom_range(0, LAST_POINT)));
      end else if (pick < 90) begin
        sample_backlog.push_back(SAMPLE_W'($urandom_range(0, 12)));
      end else begin
        sample_backlog.push_back(SAMPLE_W'($urandom_range(TOP_COUNT - 12, 1023)));
      end
    end
    total_words = sample_backlog.size();

    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_words) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
